>>> src/rebt_pkg.sv
// shared types and constants of the rotation edge blanking tracker
`default_nettype none
package rebt_pkg;

  localparam int unsigned TS_W   = 32;
  localparam int unsigned T16_W  = 16;
  localparam int unsigned THR_W  = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned N_W    = 12;
  localparam int unsigned X_W    = 13;
  localparam int unsigned V_W    = 25;
  localparam int unsigned P_W    = 24;
  localparam int unsigned XX_W   = 26;
  localparam int unsigned DTX_W  = 18;
  localparam int unsigned W_W    = 21;
  localparam int unsigned RCP_W  = 22;
  localparam int unsigned NUM_W  = 38;
  localparam int unsigned CNT_W  = 6;

  localparam logic [1:0] OP_EDGE    = 2'd0;
  localparam logic [1:0] OP_SHIFT   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_SINGLE = 2'd1;
  localparam logic [1:0] REQ_MULTI  = 2'd2;

  localparam logic [IDX_W-1:0] REG_BOUNCE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_PULSE = 2'd2;
  localparam logic [IDX_W-1:0] REG_MIN_WIN   = 2'd3;

  localparam logic [T16_W-1:0] BOUNCE_RST    = 16'd200;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 20'd10000;
  localparam logic [T16_W-1:0] MIN_PULSE_RST = 16'd70;
  localparam logic [T16_W-1:0] MIN_WIN_RST   = 16'd1000;

  localparam logic [T16_W-1:0] WINDOW_GUARD  = 16'd50;
  localparam logic [DTX_W-1:0] DIV_STEP      = 18'd30;
  localparam logic [T16_W-1:0] RECIP30       = 16'd34953;
  localparam int unsigned      RECIP30_SH    = 20;

  // window scaling reciprocals, exact for numerators below 2^21
  localparam logic [RCP_W-1:0] RECIP5        = 22'd3355444;
  localparam logic [RCP_W-1:0] RECIP7        = 22'd2396746;
  localparam int unsigned      RECIP_SH      = 24;

  localparam logic [2:0] LVL_IDLE  = 3'd0;
  localparam logic [2:0] LVL_SPIN  = 3'd1;
  localparam logic [2:0] LVL_FIRST = 3'd2;
  localparam logic [2:0] LVL_TRACK = 3'd3;
  localparam logic [2:0] LVL_HAND  = 3'd4;
  localparam logic [2:0] LVL_PWM1  = 3'd5;
  localparam logic [2:0] LVL_PWMN  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NDIV, ST_VSUM, ST_DPROD, ST_DIVX, ST_XSQ, ST_XA,
    ST_DIVQ, ST_DTX, ST_SCALE, ST_FIN
  } rebt_state_t;

  // divide a 16-bit value by 30 through a reciprocal multiply
  function automatic logic [N_W-1:0] div30(input logic [T16_W-1:0] v);
    logic [2*T16_W-1:0] p;
    p = (2*T16_W)'(v) * (2*T16_W)'(RECIP30);
    return p[RECIP30_SH +: N_W];
  endfunction

endpackage
`default_nettype wire

>>> src/rebt_ifs.sv
// input and result channel interfaces
`default_nettype none
interface rebt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] timestamp;
  logic [15:0] cmd_on_time;
  modport source (output valid, opcode, timestamp, cmd_on_time, input ready);
  modport sink (input valid, opcode, timestamp, cmd_on_time, output ready);
endinterface

interface rebt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  run_level;
  logic [15:0] ready_delay;
  logic        pulse_on;
  logic [15:0] on_time;
  logic        notify;
  logic [31:0] report_interval;
  logic [15:0] measured_on_time;
  logic [1:0]  pwm_request;
  logic [31:0] pwm_period;
  modport source (output valid, run_level, ready_delay, pulse_on, on_time, notify,
    report_interval, measured_on_time, pwm_request, pwm_period, input ready);
  modport sink (input valid, run_level, ready_delay, pulse_on, on_time, notify,
    report_interval, measured_on_time, pwm_request, pwm_period, output ready);
endinterface
`default_nettype wire

>>> src/rotation_edge_blanking_tracker.sv
// Tracks rotation sensor edges and run levels and computes the blanking delay per edge.
// Shift, restart and edges in levels 0, 1 and 4 to 6 (and edges whose older interval is
// zero) have their result registered on transfer. An edge in levels 2 and 3 runs the
// prediction through one shared restoring divider (38 quotient bits, one per cycle) twice
// when the new interval divided by 30 is below the older one, and then scales the window
// by 4/5 or 6/7 with a reciprocal multiply. The block takes no item while the prediction
// runs. The result sits in an output register; the next item is accepted once that
// register is empty or transfers in the same cycle.
`default_nettype none
module rotation_edge_blanking_tracker
  import rebt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  rebt_in_if.sink               in_ch,
  rebt_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  rebt_state_t state_r, state_nxt;

  logic [T16_W-1:0] bounce_r, minp_r, minw_r;
  logic [THR_W-1:0] thr_r;
  logic [2:0]       level_r;
  logic [TS_W-1:0]  last_ts_r, first_r, latest_r;
  logic             seen_r;
  logic [T16_W-1:0] lwin_r, lon_r;

  logic [T16_W-1:0] dtn_r, dto_r, cmd_r, meas_r;
  logic [N_W-1:0]   n0_r, n1_r;
  logic [V_W-1:0]   v0_r;
  logic [P_W-1:0]   p_r;
  logic [X_W-1:0]   x_r;
  logic [XX_W-1:0]  xx_r;
  logic [W_W-1:0]   wnum_r;
  logic [T16_W-1:0] t1_r;

  logic [NUM_W-1:0] div_quo_r;
  logic [V_W-1:0]   div_rem_r, div_den_r;
  logic [CNT_W-1:0] div_cnt_r;
  logic             div_ld;
  logic [NUM_W-1:0] div_ld_num;
  logic [V_W-1:0]   div_ld_den;
  logic [V_W:0]     div_trial;

  logic             out_valid_r, out_pon_r, out_note_r;
  logic [2:0]       out_level_r;
  logic [T16_W-1:0] out_ready_r, out_ton_r, out_meas_r;
  logic [TS_W-1:0]  out_rep_r, out_per_r;
  logic [1:0]       out_req_r;

  logic             out_free, in_fire, start_long, fin_go;
  logic [TS_W-1:0]  dt_c, lat_sum_c;
  logic [T16_W-1:0] dtn_c, dto_c;
  logic [X_W-1:0]   xdiff_c;
  logic [DTX_W-1:0] dtx_c;
  logic [W_W+RCP_W-1:0] wprod_c;
  logic [T16_W-1:0] t1_c, g_c, ton_c;
  logic             fire_c;

  function automatic logic [W_W-1:0] wscale(input logic [DTX_W-1:0] d,
                                            input logic first_win);
    logic [W_W-1:0] m;
    m = first_win ? (W_W'(d) << 2) : W_W'(d) * W_W'(6);
    return m;
  endfunction

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign dt_c       = in_ch.timestamp - last_ts_r;
  assign lat_sum_c  = latest_r + dt_c;
  assign dtn_c      = (level_r == LVL_FIRST) ? lat_sum_c[T16_W-1:0] : dt_c[T16_W-1:0];
  assign dto_c      = (level_r == LVL_FIRST) ? first_r[T16_W-1:0] : latest_r[T16_W-1:0];
  assign start_long = in_fire && (in_ch.opcode == OP_EDGE)
                      && (level_r == LVL_FIRST || level_r == LVL_TRACK) && (dto_c != '0);

  assign xdiff_c = x_r - div_quo_r[X_W+1:2];
  assign dtx_c   = DTX_W'(xdiff_c) * DIV_STEP;
  assign div_trial = {div_rem_r, div_quo_r[NUM_W-1]};

  assign wprod_c = (W_W+RCP_W)'(wnum_r)
                   * ((lwin_r == '0) ? (W_W+RCP_W)'(RECIP5) : (W_W+RCP_W)'(RECIP7));

  assign t1_c   = t1_r;
  assign g_c    = t1_c - WINDOW_GUARD;
  assign fire_c = (g_c > minw_r) && (cmd_r > minp_r);
  assign ton_c  = (cmd_r < g_c) ? cmd_r : g_c;
  assign fin_go = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    div_ld     = 1'b0;
    div_ld_num = '0;
    div_ld_den = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start_long) state_nxt = ST_NDIV;
      end
      ST_NDIV: begin
        if (n1_r > n0_r) begin
          state_nxt = ST_VSUM;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_VSUM: state_nxt = ST_DPROD;
      ST_DPROD: begin
        div_ld     = 1'b1;
        div_ld_num = NUM_W'(p_r) * NUM_W'({1'b0, n0_r} + {1'b0, n1_r});
        div_ld_den = v0_r;
        state_nxt  = ST_DIVX;
      end
      ST_DIVX: begin
        if (div_cnt_r == '0) state_nxt = ST_XSQ;
      end
      ST_XSQ: state_nxt = ST_XA;
      ST_XA: begin
        div_ld     = 1'b1;
        div_ld_num = NUM_W'(xx_r) * NUM_W'(n1_r - n0_r);
        div_ld_den = v0_r;
        state_nxt  = ST_DIVQ;
      end
      ST_DIVQ: begin
        if (div_cnt_r == '0) state_nxt = ST_DTX;
      end
      ST_DTX: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_ld) begin
      div_cnt_r <= CNT_W'(NUM_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ld) begin
      div_quo_r <= div_ld_num;
      div_rem_r <= '0;
      div_den_r <= div_ld_den;
    end else if (div_cnt_r != '0) begin
      if (div_trial >= {1'b0, div_den_r}) begin
        div_rem_r <= V_W'(div_trial - {1'b0, div_den_r});
        div_quo_r <= {div_quo_r[NUM_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_trial[V_W-1:0];
        div_quo_r <= {div_quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  // prediction datapath
  always_ff @(posedge clk) begin
    if (start_long) begin
      dtn_r  <= dtn_c;
      dto_r  <= dto_c;
      cmd_r  <= in_ch.cmd_on_time;
      meas_r <= (level_r == LVL_TRACK) ? lon_r : '0;
    end
    if (state_r == ST_NDIV || start_long) begin
      n0_r <= div30(start_long ? dtn_c : dtn_r);
      n1_r <= div30(start_long ? dto_c : dto_r);
    end
    if (state_r == ST_VSUM) begin
      v0_r <= V_W'(P_W'(n1_r) * P_W'(n1_r)) + (V_W'(P_W'(n1_r) * P_W'(n0_r)) << 1)
              - V_W'(P_W'(n0_r) * P_W'(n0_r));
      p_r  <= P_W'(n0_r) * P_W'(n1_r);
    end
    if (state_r == ST_DIVX && div_cnt_r == '0) x_r <= div_quo_r[X_W-1:0];
    if (state_r == ST_XSQ) xx_r <= XX_W'(x_r) * XX_W'(x_r);
    if (state_r == ST_NDIV) wnum_r <= wscale(DTX_W'(dtn_r), lwin_r == '0);
    if (state_r == ST_DTX) wnum_r <= wscale(dtx_c, lwin_r == '0);
    if (state_r == ST_SCALE) t1_r <= wprod_c[RECIP_SH +: T16_W];
  end

  // run state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_r    <= BOUNCE_RST;
      thr_r       <= THRESHOLD_RST;
      minp_r      <= MIN_PULSE_RST;
      minw_r      <= MIN_WIN_RST;
      level_r     <= LVL_IDLE;
      last_ts_r   <= '0;
      seen_r      <= 1'b0;
      first_r     <= '0;
      latest_r    <= '0;
      lwin_r      <= '0;
      lon_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOUNCE:    bounce_r <= cfg_wdata[T16_W-1:0];
          REG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
          REG_MIN_PULSE: minp_r   <= cfg_wdata[T16_W-1:0];
          REG_MIN_WIN:   minw_r   <= cfg_wdata[T16_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (in_fire) begin
        out_ready_r <= '0;
        out_pon_r   <= 1'b0;
        out_ton_r   <= '0;
        out_note_r  <= 1'b0;
        out_meas_r  <= '0;
        out_req_r   <= REQ_NONE;
        out_per_r   <= '0;
        out_level_r <= level_r;
        out_rep_r   <= latest_r;
        out_valid_r <= !start_long;
        priority case (in_ch.opcode)
          OP_EDGE: begin
            last_ts_r <= in_ch.timestamp;
            seen_r    <= 1'b1;
            priority case (level_r)
              LVL_IDLE: begin
                out_ready_r <= bounce_r;
                lon_r       <= '0;
                first_r     <= dt_c;
                if (seen_r && dt_c < TS_W'(thr_r)) begin
                  level_r     <= LVL_SPIN;
                  out_level_r <= LVL_SPIN;
                  out_note_r  <= 1'b1;
                end
              end
              LVL_SPIN: begin
                out_ready_r <= bounce_r;
                lon_r       <= '0;
                if (latest_r == '0) begin
                  first_r   <= first_r + dt_c;
                  latest_r  <= TS_W'(1);
                  out_rep_r <= TS_W'(1);
                end else begin
                  latest_r    <= dt_c;
                  out_rep_r   <= dt_c;
                  level_r     <= LVL_FIRST;
                  out_level_r <= LVL_FIRST;
                end
              end
              LVL_FIRST, LVL_TRACK: begin
                level_r     <= LVL_TRACK;
                out_level_r <= LVL_TRACK;
                out_note_r  <= 1'b1;
                out_ready_r <= bounce_r;
                if (level_r == LVL_FIRST) begin
                  latest_r  <= lat_sum_c;
                  out_rep_r <= lat_sum_c;
                end else begin
                  latest_r   <= dt_c;
                  out_rep_r  <= dt_c;
                  out_meas_r <= lon_r;
                end
                if (dto_c == '0) lon_r <= '0;
              end
              LVL_HAND, LVL_PWM1, LVL_PWMN: begin
                latest_r    <= dt_c;
                out_rep_r   <= dt_c;
                out_per_r   <= dt_c;
                out_note_r  <= 1'b1;
                out_req_r   <= (level_r == LVL_PWMN) ? REQ_MULTI : REQ_SINGLE;
                if (level_r != LVL_PWMN) begin
                  level_r     <= LVL_PWM1;
                  out_level_r <= LVL_PWM1;
                end
              end
              default: ;
            endcase
          end
          OP_SHIFT: begin
            if (level_r == LVL_TRACK) begin
              level_r     <= LVL_HAND;
              out_level_r <= LVL_HAND;
            end else if (level_r == LVL_PWM1) begin
              level_r     <= LVL_PWMN;
              out_level_r <= LVL_PWMN;
            end
          end
          OP_RESTART: begin
            level_r     <= LVL_IDLE;
            out_level_r <= LVL_IDLE;
            first_r     <= '0;
            latest_r    <= '0;
            out_rep_r   <= '0;
            lwin_r      <= '0;
            lon_r       <= '0;
          end
          default: ;
        endcase
      end else if (fin_go) begin
        out_valid_r <= 1'b1;
        out_level_r <= level_r;
        out_ready_r <= t1_c;
        out_pon_r   <= fire_c;
        out_ton_r   <= fire_c ? ton_c : '0;
        out_note_r  <= 1'b1;
        out_rep_r   <= latest_r;
        out_meas_r  <= meas_r;
        out_req_r   <= REQ_NONE;
        out_per_r   <= '0;
        lwin_r      <= t1_c;
        lon_r       <= fire_c ? ton_c : '0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.run_level        = out_level_r;
  assign out_ch.ready_delay      = out_ready_r;
  assign out_ch.pulse_on         = out_pon_r;
  assign out_ch.on_time          = out_ton_r;
  assign out_ch.notify           = out_note_r;
  assign out_ch.report_interval  = out_rep_r;
  assign out_ch.measured_on_time = out_meas_r;
  assign out_ch.pwm_request      = out_req_r;
  assign out_ch.pwm_period       = out_per_r;

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready)
    else $error("input taken during prediction");
  a_divider_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FIN) |-> div_cnt_r == '0)
    else $error("divider running outside its steps");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_PWMN)
    else $error("run level out of range");
  a_pwm_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_req_r != REQ_NONE |->
      (out_level_r == LVL_PWM1 || out_level_r == LVL_PWMN))
    else $error("pwm request outside pwm levels");
  a_pulse_gate: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_pon_r == (out_ton_r != '0)) || !out_pon_r)
    else $error("pulse without on-time");
`endif

endmodule
`default_nettype wire

>>> tb/rotation_edge_blanking_tracker_test.sv
// self-checking testbench for the rotation edge blanking tracker
`timescale 1ns / 100ps
`default_nettype none
module rotation_edge_blanking_tracker_test;
  import rebt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_WAIT  = 200;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] timestamp;
    logic [15:0] cmd_on_time;
  } edge_item_t;

  typedef struct packed {
    logic [2:0]  run_level;
    logic [15:0] ready_delay;
    logic        pulse_on;
    logic [15:0] on_time;
    logic        notify;
    logic [31:0] report_interval;
    logic [15:0] measured_on_time;
    logic [1:0]  pwm_request;
    logic [31:0] pwm_period;
  } track_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  rebt_in_if  in_if ();
  rebt_out_if out_if ();

  rotation_edge_blanking_tracker u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  edge_item_t    pending_items[$];
  track_result_t expected_results[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   pulses_seen;
  int unsigned   pwm_seen;
  bit            no_idle;
  logic [31:0]   stim_time;

  // tracker copy: configuration and state
  logic [15:0] m_bounce, m_min_pulse, m_min_win;
  logic [19:0] m_thresh;
  logic [2:0]  m_level;
  logic [31:0] m_last_ts, m_first_iv, m_latest_iv;
  logic        m_seen;
  logic [15:0] m_last_win, m_last_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] window_delay(input logic [15:0] dtn, input logic [15:0] dto,
                                               input logic [15:0] cmd, output logic pon,
                                               output logic [15:0] ton);
    longint n0, n1, a, dtx, w, v0, d0, x;
    logic [15:0] t1, g;
    pon = 1'b0;
    ton = '0;
    if (dto == 0) begin
      m_last_on = '0;
      return m_bounce;
    end
    n1 = longint'(dto / 30);
    n0 = longint'(dtn / 30);
    a = n1 - n0;
    dtx = longint'(dtn);
    if (a > 0) begin
      v0 = -(n0 * n0) + n1 * n1 + 2 * (n1 * n0);
      d0 = n0 * n1 * (n0 + n1);
      if (v0 > 0) begin
        x = d0 / v0;
        dtx = (x - ((x * x * a) / v0) / 4) * 30;
      end
    end
    w = (m_last_win == 0) ? (dtx * 4) / 5 : (dtx * 6) / 7;
    t1 = w[15:0];
    m_last_win = t1;
    g = t1 - 16'd50;
    if (g > m_min_win && cmd > m_min_pulse) begin
      m_last_on = (cmd < g) ? cmd : g;
      pon = 1'b1;
      ton = m_last_on;
    end else begin
      m_last_on = '0;
    end
    return t1;
  endfunction

  function automatic track_result_t track_step(input edge_item_t it);
    track_result_t r;
    logic [31:0] dt;
    logic slow;
    r = '0;
    if (it.opcode == OP_EDGE) begin
      dt = it.timestamp - m_last_ts;
      slow = !m_seen;
      m_last_ts = it.timestamp;
      m_seen = 1'b1;
      case (m_level)
        LVL_IDLE: begin
          r.ready_delay = window_delay(dt[15:0], 16'd0, it.cmd_on_time, r.pulse_on, r.on_time);
          m_first_iv = dt;
          if (!slow && dt < {12'd0, m_thresh}) begin
            m_level = LVL_SPIN;
            r.notify = 1'b1;
          end
        end
        LVL_SPIN: begin
          r.ready_delay = window_delay(dt[15:0], 16'd0, it.cmd_on_time, r.pulse_on, r.on_time);
          if (m_latest_iv == 0) begin
            m_first_iv = m_first_iv + dt;
            m_latest_iv = 32'd1;
          end else begin
            m_latest_iv = dt;
            m_level = LVL_FIRST;
          end
        end
        LVL_FIRST: begin
          m_latest_iv = m_latest_iv + dt;
          r.ready_delay = window_delay(m_latest_iv[15:0], m_first_iv[15:0], it.cmd_on_time,
                                       r.pulse_on, r.on_time);
          m_level = LVL_TRACK;
          r.notify = 1'b1;
        end
        LVL_TRACK: begin
          r.measured_on_time = m_last_on;
          r.ready_delay = window_delay(dt[15:0], m_latest_iv[15:0], it.cmd_on_time,
                                       r.pulse_on, r.on_time);
          m_latest_iv = dt;
          r.notify = 1'b1;
        end
        LVL_HAND, LVL_PWM1: begin
          m_level = LVL_PWM1;
          m_latest_iv = dt;
          r.pwm_request = REQ_SINGLE;
          r.pwm_period = dt;
          r.notify = 1'b1;
        end
        LVL_PWMN: begin
          m_latest_iv = dt;
          r.pwm_request = REQ_MULTI;
          r.pwm_period = dt;
          r.notify = 1'b1;
        end
        default: ;
      endcase
    end else if (it.opcode == OP_SHIFT) begin
      if (m_level == LVL_TRACK) m_level = LVL_HAND;
      else if (m_level == LVL_PWM1) m_level = LVL_PWMN;
    end else if (it.opcode == OP_RESTART) begin
      m_level = LVL_IDLE;
      m_first_iv = '0;
      m_latest_iv = '0;
      m_last_win = '0;
      m_last_on = '0;
    end
    r.run_level = m_level;
    r.report_interval = m_latest_iv;
    return r;
  endfunction

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at transfer %0d: %s got %0h expected %0h", results_seen, field, got,
             want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // input driver
  int unsigned in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.opcode <= '0;
      in_if.timestamp <= '0;
      in_if.cmd_on_time <= '0;
      in_gap = 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        edge_item_t it;
        it = pending_items.pop_front();
        in_if.opcode <= it.opcode;
        in_if.timestamp <= it.timestamp;
        in_if.cmd_on_time <= it.cmd_on_time;
        in_if.valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls
  int unsigned out_stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_stall = pick_gap();
      out_if.ready <= (out_stall == 0);
    end
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        edge_item_t it;
        it.opcode = in_if.opcode;
        it.timestamp = in_if.timestamp;
        it.cmd_on_time = in_if.cmd_on_time;
        expected_results.push_back(track_step(it));
        items_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        track_result_t w;
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("unexpected result transfer %0d", results_seen);
          errors++;
        end else begin
          w = expected_results.pop_front();
          if (out_if.run_level !== w.run_level) report("run_level", out_if.run_level, w.run_level);
          if (out_if.ready_delay !== w.ready_delay)
            report("ready_delay", out_if.ready_delay, w.ready_delay);
          if (out_if.pulse_on !== w.pulse_on) report("pulse_on", out_if.pulse_on, w.pulse_on);
          if (out_if.on_time !== w.on_time) report("on_time", out_if.on_time, w.on_time);
          if (out_if.notify !== w.notify) report("notify", out_if.notify, w.notify);
          if (out_if.report_interval !== w.report_interval)
            report("report_interval", out_if.report_interval, w.report_interval);
          if (out_if.measured_on_time !== w.measured_on_time)
            report("measured_on_time", out_if.measured_on_time, w.measured_on_time);
          if (out_if.pwm_request !== w.pwm_request)
            report("pwm_request", out_if.pwm_request, w.pwm_request);
          if (out_if.pwm_period !== w.pwm_period)
            report("pwm_period", out_if.pwm_period, w.pwm_period);
          if (w.pulse_on) pulses_seen++;
          if (w.pwm_request != REQ_NONE) pwm_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] ts, input logic [15:0] cmd);
    edge_item_t it;
    it.opcode = op;
    it.timestamp = ts;
    it.cmd_on_time = cmd;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] rand_cmd();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 200));
      1: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(100, 3000));
    endcase
  endfunction

  task automatic push_edge(input logic [31:0] dt);
    stim_time = stim_time + dt;
    push_item(OP_EDGE, stim_time, rand_cmd());
  endtask

  // mostly decelerating intervals with some speed-ups
  function automatic logic [31:0] next_interval(input logic [31:0] prev);
    case ($urandom_range(0, 9))
      0: return $urandom_range(30, 70000);
      1, 2: return prev - prev / 32'($urandom_range(4, 16));
      default: return prev + prev / 32'($urandom_range(4, 40));
    endcase
  endfunction

  // restart, climb toward the top level, shifting on the way (some runs stop before the first shift)
  task automatic climb_run();
    logic [31:0] iv;
    int unsigned n3, n5, n6;
    push_item(OP_RESTART, $urandom, rand_cmd());
    iv = $urandom_range(300, 9000);
    push_edge(iv);
    push_edge(iv);
    for (int i = 0; i < 3; i++) begin
      iv = next_interval(iv);
      push_edge(iv);
    end
    n3 = $urandom_range(1, 8);
    for (int i = 0; i < n3; i++) begin
      iv = next_interval(iv);
      push_edge(iv);
    end
    if ($urandom_range(0, 9) == 0) return;
    push_item(OP_SHIFT, $urandom, rand_cmd());
    n5 = $urandom_range(1, 3);
    for (int i = 0; i < n5; i++) push_edge(next_interval(iv));
    push_item(OP_SHIFT, $urandom, rand_cmd());
    n6 = $urandom_range(1, 3);
    for (int i = 0; i < n6; i++) push_edge($urandom_range(0, 40000));
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 5))
      0, 1: push_edge($urandom_range(0, 70000));
      2: push_item(OP_EDGE, $urandom, rand_cmd());
      3: push_item(OP_SHIFT, $urandom, 16'($urandom));
      4: push_item(OP_RESTART, $urandom, 16'($urandom));
      default: push_item(OP_UNUSED, $urandom, 16'($urandom));
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BOUNCE:    m_bounce = val[15:0];
      REG_THRESHOLD: m_thresh = val[19:0];
      REG_MIN_PULSE: m_min_pulse = val[15:0];
      default:       m_min_win = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [19:0] b, input logic [19:0] t, input logic [19:0] p,
                           input logic [19:0] w);
    wait_idle();
    write_reg(REG_BOUNCE, b);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_MIN_PULSE, p);
    write_reg(REG_MIN_WIN, w);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    pulses_seen = 0;
    pwm_seen = 0;
    no_idle = 1'b0;
    stim_time = '0;
    m_bounce = BOUNCE_RST;
    m_thresh = THRESHOLD_RST;
    m_min_pulse = MIN_PULSE_RST;
    m_min_win = MIN_WIN_RST;
    m_level = LVL_IDLE;
    m_last_ts = '0;
    m_seen = 1'b0;
    m_first_iv = '0;
    m_latest_iv = '0;
    m_last_win = '0;
    m_last_on = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first slow edge, extremes, zero older interval, every opcode
    push_item(OP_EDGE, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_EDGE, 32'd0, 16'd0);
    push_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_SHIFT, 32'd0, 16'd0);
    push_item(OP_EDGE, 32'd5000, 16'd500);
    push_item(OP_EDGE, 32'd65536, 16'd500);
    push_item(OP_EDGE, 32'd75536, 16'd500);
    push_item(OP_EDGE, 32'd85000, 16'd500);
    push_item(OP_EDGE, 32'd95600, 16'hFFFF);
    push_item(OP_SHIFT, 32'd0, 16'd0);
    push_item(OP_SHIFT, 32'd0, 16'd0);
    push_item(OP_EDGE, 32'd106000, 16'd0);
    push_item(OP_SHIFT, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_EDGE, 32'd117000, 16'd0);
    push_item(OP_EDGE, 32'd117000, 16'd0);
    push_item(OP_RESTART, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(OP_EDGE, 32'd117010, 16'd71);
    push_item(OP_EDGE, 32'd117020, 16'd71);
    push_item(OP_EDGE, 32'd117030, 16'd71);
    push_item(OP_EDGE, 32'd117040, 16'd71);
    push_item(OP_EDGE, 32'd117041, 16'd71);
    stim_time = 32'd117041;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: write_all(20'd0, 20'd0, 20'd0, 20'd0);
        2: write_all(20'hFFFF, 20'd1000000, 20'hFFFF, 20'hFFFF);
        3: write_all(20'd1, 20'd1000000, 20'd0, 20'd0);
        default: write_all(20'($urandom_range(0, 65535)), 20'($urandom_range(0, 1000000)),
                           20'($urandom_range(0, 2000)), 20'($urandom_range(0, 3000)));
      endcase
      no_idle = (phase == 3);
      if (phase == 4) stim_time = 32'hFFFF_0000 + $urandom_range(0, 65535);
      while (pending_items.size() < 190) begin
        if ($urandom_range(0, 9) < 7) climb_run();
        else noise_item();
      end
    end

    wait_idle();
    $display("transfers: %0d items in, %0d results checked", items_sent, results_seen);
    $display("drive pulses predicted %0d, pwm requests %0d", pulses_seen, pwm_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> rotation_edge_blanking_tracker.f
src/rebt_pkg.sv
src/rebt_ifs.sv
src/rotation_edge_blanking_tracker.sv
tb/rotation_edge_blanking_tracker_test.sv
